### src/cctr_pkg.sv
package cctr_pkg;

  localparam int ADDR_W           = 32;
  localparam int TAG_W            = 32;
  localparam int RANK_W           = 10;
  localparam int SET_WAYS         = 4;
  localparam int PADDR_W          = 4;
  localparam int PDATA_W          = 32;
  localparam int DEF_MAX_LINES    = 1024;
  localparam int DEF_ADDRESS_BITS = 32;

  localparam logic [3:0] LINE_LOG2_RESET  = 4'd10;
  localparam logic [3:0] BLOCK_LOG2_RESET = 4'd4;
  localparam logic [3:0] BLOCK_LOG2_MAX   = 4'd12;
  localparam logic [4:0] LINE_LOG2_MIN    = 5'd2;

  typedef enum logic [1:0] {
    REG_LINE_COUNT  = 2'd0,
    REG_BLOCK_BYTES = 2'd1,
    REG_ORG         = 2'd2,
    REG_POLICY      = 2'd3
  } reg_idx_t;

  localparam logic [1:0] ORG_DIRECT   = 2'd0;
  localparam logic [1:0] ORG_FOUR_WAY = 2'd1;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_MRI  = 2'd2;

  typedef enum logic [1:0] {
    MODE_FIFO = 2'd0,
    MODE_LRU  = 2'd1,
    MODE_MRI  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [3:0] line_count_log2;
    logic [3:0] block_bytes_log2;
    logic [1:0] organization;
    logic [1:0] policy;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } line_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_DECIDE, ST_SWEEP, ST_SWEEP_DRAIN, ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic cnt_clr;
    logic load;
    logic issue;
    logic sweep;
    logic wr_one;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic issue_last;
    logic found;
    logic need_sweep;
  } sts_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [TAG_W-1:0] victim_tag;
  } res_t;

endpackage

### src/cctr_ctrl.sv
module cctr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           cfg_wr,
  input  logic           out_free,
  input  cctr_pkg::sts_t sts,
  output logic           in_ready,
  output logic           out_load,
  output cctr_pkg::cmd_t cmd
);
  import cctr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:       if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:        if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:        if (sts.issue_last) state_nxt = ST_DRAIN;
      ST_DRAIN:       state_nxt = ST_DECIDE;
      ST_DECIDE:      state_nxt = sts.need_sweep ? ST_SWEEP : ST_FINISH;
      ST_SWEEP:       if (sts.issue_last) state_nxt = ST_SWEEP_DRAIN;
      ST_SWEEP_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH:      if (out_free) state_nxt = ST_IDLE;
      default:        state_nxt = ST_CLEAR;
    endcase
    // any register write wipes the store
    if (cfg_wr) state_nxt = ST_CLEAR;
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    cmd.cnt_clr = cfg_wr;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready = !cfg_wr;
        cmd.load = in_valid && !cfg_wr;
      end
      ST_SCAN:   cmd.issue = 1'b1;
      ST_DECIDE: cmd.wr_one = !sts.found && !sts.need_sweep;
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        cmd.sweep = 1'b1;
      end
      ST_FINISH: out_load = out_free && !cfg_wr;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> state_r == ST_CLEAR)
    else $error("register write not followed by clearing pass");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("input ready outside idle");
  a_load_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == ST_FINISH && out_free))
    else $error("result loaded outside finish");
`endif

endmodule

### src/cctr_dp.sv
module cctr_dp #(
  parameter int MAX_LINES    = cctr_pkg::DEF_MAX_LINES,
  parameter int ADDRESS_BITS = cctr_pkg::DEF_ADDRESS_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cctr_pkg::cfg_t              cfg,
  input  logic [cctr_pkg::ADDR_W-1:0] in_address,
  input  cctr_pkg::cmd_t              cmd,
  output cctr_pkg::sts_t              sts,
  output cctr_pkg::res_t              res
);
  import cctr_pkg::*;

  localparam int IW = $clog2(MAX_LINES);
  localparam int NW = IW + 1;
  localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  line_t mem [MAX_LINES];

  // per-item decode
  logic [ADDR_W-1:0] addr_m, addr_sh, tag_d;
  logic [3:0]        ob;
  logic [4:0]        lc, lg, sl;
  logic [NW-1:0]     lines, n_d;
  logic [IW-1:0]     base_d, set_mask;
  mode_t             mode_d;
  logic              dm_d;

  always_comb begin
    addr_m  = in_address & AMASK;
    ob      = (cfg.block_bytes_log2 > BLOCK_LOG2_MAX) ? BLOCK_LOG2_MAX : cfg.block_bytes_log2;
    lc      = {1'b0, cfg.line_count_log2};
    if (lc < LINE_LOG2_MIN) lg = LINE_LOG2_MIN;
    else if (lc > 5'(IW))   lg = 5'(IW);
    else                    lg = lc;
    sl       = lg - 5'd2;
    addr_sh  = addr_m >> ob;
    lines    = NW'(1) << lg;
    set_mask = IW'((NW'(1) << sl) - NW'(1));
    dm_d     = 1'b0;
    case (cfg.organization)
      ORG_DIRECT: begin
        base_d = IW'(addr_sh) & IW'(lines - NW'(1));
        n_d    = NW'(1);
        tag_d  = addr_m >> (6'(ob) + 6'(lg));
        mode_d = MODE_FIFO;
        dm_d   = 1'b1;
      end
      ORG_FOUR_WAY: begin
        base_d = (IW'(addr_sh) & set_mask) << 2;
        n_d    = NW'(SET_WAYS);
        tag_d  = addr_m >> (6'(ob) + 6'(sl));
        mode_d = (cfg.policy == POL_FIFO) ? MODE_FIFO : MODE_LRU;
      end
      default: begin
        base_d = '0;
        n_d    = lines;
        tag_d  = addr_sh;
        case (cfg.policy)
          POL_FIFO: mode_d = MODE_FIFO;
          POL_LRU:  mode_d = MODE_LRU;
          default:  mode_d = MODE_MRI;
        endcase
      end
    endcase
  end

  logic [IW-1:0]     base_r, cnt_r, cnt_nxt, rd_off_r, hit_off_r, free_off_r, vic_off_r;
  logic [NW-1:0]     n_r, vc_r;
  logic [TAG_W-1:0]  tag_r, vic_tag_r;
  logic [RANK_W-1:0] hit_rank_r, n1;
  mode_t             mode_r;
  logic              dm_r, rd_vld_r, rd_sweep_r, found_r, has_free_r;
  line_t             mem_q_r, sweep_w, wr_data;
  logic [IW-1:0]     wr_addr;
  logic              wr_en, vic_match;

  assign n1             = RANK_W'(n_r - NW'(1));
  assign sts.issue_last = ({1'b0, cnt_r} == n_r - NW'(1));
  assign sts.clr_last   = (cnt_r == IW'(MAX_LINES - 1));
  assign sts.found      = found_r;
  assign sts.need_sweep = found_r ? (mode_r == MODE_LRU && !dm_r)
                                  : (!has_free_r && !dm_r && mode_r != MODE_MRI);

  always_comb begin
    if (cmd.cnt_clr || cmd.load)           cnt_nxt = '0;
    else if (cmd.clr_wr)                   cnt_nxt = cnt_r + IW'(1);
    else if (cmd.issue && sts.issue_last)  cnt_nxt = '0;
    else if (cmd.issue)                    cnt_nxt = cnt_r + IW'(1);
    else                                   cnt_nxt = cnt_r;
  end

  // line that would be chosen when the group is full
  assign vic_match = (rd_off_r == '0) ||
                     ((mode_r == MODE_MRI) ? (mem_q_r.rank == n1) : (mem_q_r.rank == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      rd_sweep_r <= 1'b0;
      found_r    <= 1'b0;
      has_free_r <= 1'b0;
      vc_r       <= '0;
      n_r        <= NW'(1);
    end else begin
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= cmd.issue;
      rd_sweep_r <= cmd.sweep;
      if (cmd.load) begin
        found_r    <= 1'b0;
        has_free_r <= 1'b0;
        vc_r       <= '0;
        n_r        <= n_d;
      end else if (rd_vld_r && !rd_sweep_r) begin
        if (mem_q_r.valid) begin
          vc_r <= vc_r + NW'(1);
          if (!found_r && mem_q_r.tag == tag_r) found_r <= 1'b1;
        end else if (!has_free_r) begin
          has_free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_off_r <= cnt_r;
    if (cmd.load) begin
      base_r <= base_d;
      tag_r  <= tag_d;
      mode_r <= mode_d;
      dm_r   <= dm_d;
    end else if (rd_vld_r && !rd_sweep_r) begin
      if (mem_q_r.valid && !found_r && mem_q_r.tag == tag_r) begin
        hit_off_r  <= rd_off_r;
        hit_rank_r <= mem_q_r.rank;
      end
      if (!mem_q_r.valid && !has_free_r) free_off_r <= rd_off_r;
      if (vic_match) begin
        vic_off_r <= rd_off_r;
        vic_tag_r <= mem_q_r.tag;
      end
    end
  end

  // rank shuffle for the word coming back during the sweep
  always_comb begin
    sweep_w = mem_q_r;
    if (found_r) begin
      if (rd_off_r == hit_off_r)
        sweep_w.rank = RANK_W'(vc_r - NW'(1));
      else if (mem_q_r.valid && mem_q_r.rank > hit_rank_r)
        sweep_w.rank = mem_q_r.rank - RANK_W'(1);
    end else begin
      if (rd_off_r == vic_off_r)
        sweep_w = '{valid: 1'b1, rank: n1, tag: tag_r};
      else if (mem_q_r.rank != '0)
        sweep_w.rank = mem_q_r.rank - RANK_W'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.wr_one) begin
      wr_en = 1'b1;
      if (has_free_r) begin
        wr_addr = base_r + free_off_r;
        wr_data = '{valid: 1'b1, rank: RANK_W'(vc_r), tag: tag_r};
      end else begin
        wr_addr = base_r + vic_off_r;
        wr_data = '{valid: 1'b1, rank: (dm_r ? '0 : n1), tag: tag_r};
      end
    end else if (rd_vld_r && rd_sweep_r) begin
      wr_en   = 1'b1;
      wr_addr = base_r + rd_off_r;
      wr_data = sweep_w;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.issue) mem_q_r <= mem[base_r + cnt_r];
  end

  assign res.hit        = found_r;
  assign res.evicted    = !found_r && !has_free_r;
  assign res.victim_tag = res.evicted ? vic_tag_r : '0;

`ifndef SYNTHESIS
  a_wr_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_one |-> !rd_vld_r)
    else $error("single write collides with sweep write");
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> vc_r != '0)
    else $error("hit without a valid line counted");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r <= n_r)
    else $error("valid count above group size");
`endif

endmodule

### src/cache_tag_replacement_model.sv
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_ready  | in_address
// out     | out       | out_valid/out_ready| out_hit, out_evicted, out_victim_tag
// cfg     | in        | psel/penable/pready| paddr, pwdata, pwrite, prdata
// one word at a time; each lookup makes a scan pass (one tag memory read per cycle)
// and, for rank updates, a read-modify-write sweep
// after reset and after every register write, a clearing pass over all MAX_LINES
// lines runs before in_ready rises; reset is synchronous, active low
// a new word is taken while a result still waits on out_ready
module cache_tag_replacement_model #(
  parameter int MAX_LINES    = cctr_pkg::DEF_MAX_LINES,
  parameter int ADDRESS_BITS = cctr_pkg::DEF_ADDRESS_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cctr_pkg::ADDR_W-1:0]  in_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic                         out_evicted,
  output logic [cctr_pkg::TAG_W-1:0]   out_victim_tag,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cctr_pkg::PADDR_W-1:0] paddr,
  input  logic [cctr_pkg::PDATA_W-1:0] pwdata,
  output logic [cctr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import cctr_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic cfg_wr, out_free, out_load, out_valid_r;
  res_t out_r;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{line_count_log2: LINE_LOG2_RESET, block_bytes_log2: BLOCK_LOG2_RESET,
                 organization: ORG_DIRECT, policy: POL_FIFO};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LINE_COUNT:  cfg_r.line_count_log2  <= pwdata[3:0];
        REG_BLOCK_BYTES: cfg_r.block_bytes_log2 <= pwdata[3:0];
        REG_ORG:         cfg_r.organization     <= pwdata[1:0];
        REG_POLICY:      cfg_r.policy           <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LINE_COUNT:  prdata = PDATA_W'(cfg_r.line_count_log2);
      REG_BLOCK_BYTES: prdata = PDATA_W'(cfg_r.block_bytes_log2);
      REG_ORG:         prdata = PDATA_W'(cfg_r.organization);
      REG_POLICY:      prdata = PDATA_W'(cfg_r.policy);
      default:         prdata = '0;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_r.hit;
  assign out_evicted    = out_r.evicted;
  assign out_victim_tag = out_r.victim_tag;

  cctr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_wr   (cfg_wr),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_ready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  cctr_dp #(
    .MAX_LINES    (MAX_LINES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_address (in_address),
    .cmd        (cmd),
    .sts        (sts),
    .res        (res)
  );

endmodule

### tb/tb_cache_tag_replacement_model.sv
`timescale 1ns / 1ps

module tb_cache_tag_replacement_model;
  import cctr_pkg::*;

  localparam int LINES_MAX = 1024;
  localparam int SETTLE    = 2 * LINES_MAX + 40;
  localparam int CLEAR_CYC = LINES_MAX + 40;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADDR_W-1:0] in_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic out_evicted;
  logic [TAG_W-1:0] out_victim_tag;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  cache_tag_replacement_model dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_address(in_address),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_evicted(out_evicted), .out_victim_tag(out_victim_tag),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the tag store
  logic [TAG_W-1:0]  sh_tag [LINES_MAX];
  logic              sh_valid [LINES_MAX];
  logic [RANK_W-1:0] sh_rank [LINES_MAX];
  logic [3:0] sh_lines_log2;
  logic [3:0] sh_block_log2;
  logic [1:0] sh_org;
  logic [1:0] sh_policy;

  res_t   expected_q[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cycles = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < LINES_MAX; i++) begin
      sh_tag[i] = '0;
      sh_valid[i] = 1'b0;
      sh_rank[i] = '0;
    end
  endfunction

  // lookup within one group of lines; returns hit/evicted/victim
  function automatic res_t group_lookup(int base, int n, logic [TAG_W-1:0] tag, mode_t mode);
    res_t r;
    int vc, hitway, victim, freeway, rk;
    bit found, has_free;
    r = '0;
    vc = 0; hitway = 0; victim = base; freeway = 0; found = 0; has_free = 0;
    for (int i = base; i < base + n; i++) begin
      if (sh_valid[i]) begin
        vc++;
        if (!found && sh_tag[i] == tag) begin
          found = 1;
          hitway = i;
        end
      end else if (!has_free) begin
        has_free = 1;
        freeway = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (mode == MODE_LRU) begin
        rk = sh_rank[hitway];
        for (int i = base; i < base + n; i++)
          if (sh_valid[i] && sh_rank[i] > rk) sh_rank[i]--;
        sh_rank[hitway] = RANK_W'(vc - 1);
      end
      return r;
    end
    if (has_free) begin
      sh_tag[freeway] = tag;
      sh_valid[freeway] = 1'b1;
      sh_rank[freeway] = RANK_W'(vc);
      return r;
    end
    r.evicted = 1'b1;
    if (mode == MODE_MRI) begin
      for (int i = base; i < base + n; i++)
        if (sh_rank[i] == RANK_W'(n - 1)) victim = i;
      r.victim_tag = sh_tag[victim];
      sh_tag[victim] = tag;
      return r;
    end
    for (int i = base; i < base + n; i++)
      if (sh_rank[i] == 0) victim = i;
    for (int i = base; i < base + n; i++)
      if (sh_rank[i] > 0) sh_rank[i]--;
    r.victim_tag = sh_tag[victim];
    sh_tag[victim] = tag;
    sh_rank[victim] = RANK_W'(n - 1);
    return r;
  endfunction

  function automatic res_t access_predict(logic [ADDR_W-1:0] addr);
    res_t r;
    int ob, lg, sl, idx;
    logic [1:0] pol;
    r = '0;
    ob = (sh_block_log2 > BLOCK_LOG2_MAX) ? BLOCK_LOG2_MAX : sh_block_log2;
    lg = (sh_lines_log2 < LINE_LOG2_MIN) ? LINE_LOG2_MIN : sh_lines_log2;
    if (lg > 10) lg = 10;
    pol = (sh_policy == 2'd3) ? POL_MRI : sh_policy;
    if (sh_org == ORG_DIRECT) begin
      idx = (addr >> ob) & ((1 << lg) - 1);
      if (sh_valid[idx]) begin
        if (sh_tag[idx] == TAG_W'(addr >> (ob + lg))) r.hit = 1'b1;
        else begin
          r.evicted = 1'b1;
          r.victim_tag = sh_tag[idx];
        end
      end
      sh_valid[idx] = 1'b1;
      sh_tag[idx] = TAG_W'(addr >> (ob + lg));
    end else if (sh_org == ORG_FOUR_WAY) begin
      sl = lg - 2;
      idx = (addr >> ob) & ((1 << sl) - 1);
      r = group_lookup(idx * SET_WAYS, SET_WAYS, TAG_W'(addr >> (ob + sl)),
                       (pol == POL_FIFO) ? MODE_FIFO : MODE_LRU);
    end else begin
      r = group_lookup(0, 1 << lg, TAG_W'(addr >> ob), mode_t'(pol));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word hit=%0b ev=%0b tag=%h", $time, out_hit,
                 out_evicted, out_victim_tag);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_hit !== exp_r.hit || out_evicted !== exp_r.evicted ||
            out_victim_tag !== exp_r.victim_tag) begin
          $display("%0t: mismatch expected hit=%0b ev=%0b tag=%h actual hit=%0b ev=%0b tag=%h",
                   $time, exp_r.hit, exp_r.evicted, exp_r.victim_tag,
                   out_hit, out_evicted, out_victim_tag);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx)); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    clear_shadow();
    case (idx)
      REG_LINE_COUNT:  sh_lines_log2 = value[3:0];
      REG_BLOCK_BYTES: sh_block_log2 = value[3:0];
      REG_ORG:         sh_org = value[1:0];
      REG_POLICY:      sh_policy = value[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // called at a falling edge; leaves valid high until the next word or an idle
  task automatic send_word(logic [ADDR_W-1:0] addr, bit check_typed, res_t typed);
    res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    pred = access_predict(addr);
    if (check_typed && pred != typed) begin
      $display("%0t: predictor disagrees with table expected %p got %p", $time, typed, pred);
      errors++;
    end
    expected_q.push_back(pred);
    @(negedge clk);
  endtask

  task automatic configure(logic [3:0] lg, logic [3:0] bb, logic [1:0] org, logic [1:0] pol);
    drain();
    reg_write(REG_LINE_COUNT, PDATA_W'(lg));
    reg_write(REG_BLOCK_BYTES, PDATA_W'(bb));
    reg_write(REG_ORG, PDATA_W'(org));
    reg_write(REG_POLICY, PDATA_W'(pol));
  endtask

  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit    typed;
    res_t  want;
  } row_t;

  // directed rows, reset configuration (1024 lines, 16-byte blocks, direct mapped)
  row_t rows[] = '{
    '{32'h0000_0000, 1, '{1'b0, 1'b0, 32'h0}},
    '{32'h0000_0000, 1, '{1'b1, 1'b0, 32'h0}},
    '{32'h0000_4000, 1, '{1'b0, 1'b1, 32'h0}},
    '{32'hFFFF_FFFF, 1, '{1'b0, 1'b0, 32'h0}},
    '{32'hFFFF_FFF0, 1, '{1'b1, 1'b0, 32'h0}},
    '{32'h0000_3FF0, 1, '{1'b0, 1'b1, 32'h3FFFF}},
    '{32'hAAAA_5555, 0, '{1'b0, 1'b0, 32'h0}},
    '{32'h5555_AAAA, 0, '{1'b0, 1'b0, 32'h0}},
    '{32'h0000_000F, 1, '{1'b0, 1'b1, 32'h1}}
  };

  // small fully associative / four-way directed sequence
  logic [ADDR_W-1:0] seq4[] = '{32'h00, 32'h10, 32'h20, 32'h30, 32'h10,
                                32'h40, 32'h00, 32'h50, 32'h40, 32'h60};

  task automatic random_phase(int count, logic [3:0] bb);
    logic [ADDR_W-1:0] pool[8];
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) begin
        // mostly a small working set so that hits and evictions happen
        a = (ADDR_W'($urandom_range(15)) << bb) ^ (pool[$urandom_range(7)] & 32'hFFFF_0000);
        a = a | ADDR_W'($urandom_range((1 << bb) - 1));
      end else begin
        a = $urandom;
      end
      send_word(a, 0, '0);
    end
  endtask

  initial begin
    res_t none;
    none = '0;
    clear_shadow();
    sh_lines_log2 = LINE_LOG2_RESET;
    sh_block_log2 = BLOCK_LOG2_RESET;
    sh_org = ORG_DIRECT;
    sh_policy = POL_FIFO;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (CLEAR_CYC) @(negedge clk);

    send_idle_pct = 30; recv_idle_pct = 71;
    foreach (rows[i]) send_word(rows[i].addr, rows[i].typed, rows[i].want);

    // extremes: four-way and fully associative with each policy, both saturations
    configure(4'd2, 4'd4, 2'd2, 2'd0);
    foreach (seq4[i]) send_word(seq4[i], 0, none);
    configure(4'd2, 4'd4, 2'd2, 2'd1);
    foreach (seq4[i]) send_word(seq4[i], 0, none);
    configure(4'd0, 4'd15, 2'd3, 2'd3);
    foreach (seq4[i]) send_word(seq4[i] << 12, 0, none);
    configure(4'd2, 4'd0, 2'd1, 2'd2);
    foreach (seq4[i]) send_word(seq4[i] >> 4, 0, none);
    configure(4'd15, 4'd12, 2'd1, 2'd0);
    foreach (seq4[i]) send_word(seq4[i] << 20, 0, none);

    // sender holds off until everything has come back
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    configure(4'd3, 4'd2, 2'd2, 2'd1);
    random_phase(110, 4'd2);
    configure(4'd4, 4'd4, 2'd1, 2'd0);
    random_phase(110, 4'd4);

    send_idle_pct = 71; recv_idle_pct = 30;
    configure(4'd3, 4'd1, 2'd2, 2'd2);
    random_phase(110, 4'd1);
    configure(4'd2, 4'd3, 2'd0, 2'd1);
    random_phase(90, 4'd3);

    send_idle_pct = 0; recv_idle_pct = 0;
    configure(4'd5, 4'd0, 2'd1, 2'd1);
    random_phase(80, 4'd0);
    configure(4'd10, 4'd12, 2'd2, 2'd0);
    random_phase(20, 4'd12);

    drain();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
